FILE: rtl/core/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash package
// Shared types, round constants and helper functions for the SHA-256 stream
// hash unit and its submodules.
// ----------------------------------------------------------------------------
package shs_pkg;

   // One input word: an optional message byte and an end-of-message mark.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } shs_req_type;

   // One result word: a digest word with its position.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } shs_rsp_type;

   // Padding modes applied to the block window.
   localparam logic [1:0] PAD_ONE    = 2'd0; // 0x80, zeros, length in one block
   localparam logic [1:0] PAD_FIRST  = 2'd1; // 0x80 and zeros to the block end
   localparam logic [1:0] PAD_SECOND = 2'd2; // zeros and length only

   // Control from the sequencer to the block window.
   typedef struct packed {
      logic       byte_we;
      logic       shift;
      logic       pad_en;
      logic [1:0] pad_mode;
   } shs_sched_ctrl_type;

   // Control from the sequencer to the round datapath.
   typedef struct packed {
      logic       load;
      logic       round;
      logic       final_add;
      logic       restart;
      logic [5:0] round_idx;
   } shs_core_ctrl_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Rotate right by a fixed amount; callers pass constants only.
   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: rtl/core/shs_msg_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 block window and message schedule
// Sixteen 32-bit words that gather message bytes, take the padding, and then
// slide once per round to deliver the expanded schedule word.
// ----------------------------------------------------------------------------
module shs_msg_sched import shs_pkg::*; (
   input  logic               clock,
   input  shs_sched_ctrl_type ctrl,
   input  logic [5:0]         fill,
   input  logic [7:0]         data_byte,
   input  logic [63:0]        length_bits,
   output logic [31:0]        w_t
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] w_new;

   // Next schedule word from the fixed taps of the window.
   assign w_new = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
   assign w_t   = w_ff[0];

   // Byte writes, padding and sliding of the window.
   always_comb begin
      logic [5:0] b;
      logic [2:0] lsel;
      logic [7:0] nb;
      b    = '0;
      lsel = '0;
      nb   = '0;
      w_in = w_ff;
      if (ctrl.shift) begin
         for (int j = 0; j < 15; j++) begin
            w_in[j] = w_ff[j + 1];
         end
         w_in[15] = w_new;
      end else if (ctrl.byte_we || ctrl.pad_en) begin
         for (int j = 0; j < 16; j++) begin
            for (int k = 0; k < 4; k++) begin
               b    = 6'(j * 4 + k);
               lsel = ~b[2:0];
               nb   = w_ff[j][8 * (3 - k) +: 8];
               if (ctrl.byte_we) begin
                  if (b == fill) begin
                     nb = data_byte;
                  end
               end else begin
                  case (ctrl.pad_mode)
                     PAD_ONE: begin
                        if (b == fill) begin
                           nb = 8'h80;
                        end else if (b >= 6'd56) begin
                           nb = length_bits[{lsel, 3'b000} +: 8];
                        end else if (b > fill) begin
                           nb = 8'h00;
                        end
                     end
                     PAD_FIRST: begin
                        if (b == fill) begin
                           nb = 8'h80;
                        end else if (b > fill) begin
                           nb = 8'h00;
                        end
                     end
                     PAD_SECOND: begin
                        if (b >= 6'd56) begin
                           nb = length_bits[{lsel, 3'b000} +: 8];
                        end else begin
                           nb = 8'h00;
                        end
                     end
                     default: begin
                        nb = w_ff[j][8 * (3 - k) +: 8];
                     end
                  endcase
               end
               w_in[j][8 * (3 - k) +: 8] = nb;
            end
         end
      end
   end

   // The window holds payload only and needs no reset.
   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

endmodule

FILE: rtl/core/shs_round_core.sv
// ----------------------------------------------------------------------------
// SHA-256 round datapath
// One compression round per cycle on the working variables, plus the chaining
// value that takes the feed-forward add at the end of each block.
// ----------------------------------------------------------------------------
module shs_round_core import shs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  shs_core_ctrl_type ctrl,
   input  logic [31:0]       w_t,
   input  logic [2:0]        rd_idx,
   output logic [31:0]       rd_word
);

   logic [31:0] hv_ff [8];
   logic [31:0] hv_in [8];
   logic [31:0] v_ff  [8];
   logic [31:0] v_in  [8];
   logic [31:0] t1;
   logic [31:0] t2;

   // Round function on the current working variables.
   assign t1 = v_ff[7] + big_sigma1(v_ff[4])
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[ctrl.round_idx] + w_t;
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign rd_word = hv_ff[rd_idx];

   // Working variable update: load at block start, then one round per cycle.
   always_comb begin
      v_in = v_ff;
      if (ctrl.load) begin
         v_in = hv_ff;
      end else if (ctrl.round) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   // Chaining value: feed-forward add after a block, initial values on restart.
   always_comb begin
      hv_in = hv_ff;
      if (ctrl.restart) begin
         hv_in = INIT_HASH;
      end else if (ctrl.final_add) begin
         for (int i = 0; i < 8; i++) begin
            hv_in[i] = hv_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= INIT_HASH;
      end else begin
         hv_ff <= hv_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

endmodule

FILE: rtl/core/sha256_hash_stream_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash unit
// Hashes a byte stream with SHA-256 and returns the digest as eight words.
// ----------------------------------------------------------------------------
// A word that carries a byte which does not complete a 64-byte block is taken
// at once. A byte that completes a block starts a compression on the one
// shared round unit: the rounds and then one feed-forward add, after which the
// next word is taken. End of message costs one padding step and one
// compression, or two of each when fewer than nine bytes of the block remain,
// followed by eight digest words, one per cycle when the result side does not
// stall. The input stalls for all of that time.
// After the last digest word the unit starts over from the initial hash.
module sha256_hash_stream_unit import shs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  shs_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output shs_rsp_type rsp_payload
);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_PAD2  = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   // What the running compression is for.
   localparam logic [1:0] K_DATA = 2'd0;
   localparam logic [1:0] K_PAD1 = 2'd1;
   localparam logic [1:0] K_LAST = 2'd2;

   logic [2:0]  state_ff,     state_in;
   logic [5:0]  fill_ff,      fill_in;
   logic [54:0] blk_cnt_ff,   blk_cnt_in;
   logic [5:0]  round_cnt_ff, round_cnt_in;
   logic [1:0]  kind_ff,      kind_in;
   logic        eom_pend_ff,  eom_pend_in;
   logic [2:0]  out_idx_ff,   out_idx_in;

   logic               req_acc;
   logic               rsp_acc;
   logic [31:0]        w_t;
   logic [31:0]        rd_word;
   logic [63:0]        length_bits;
   shs_sched_ctrl_type sched_ctrl;
   shs_core_ctrl_type  core_ctrl;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_acc   = rsp_valid && !rsp_stall;

   // Completed blocks count 512 bits each, so the length needs no adder.
   assign length_bits = {blk_cnt_ff, fill_ff, 3'b000};

   assign rsp_payload.digest_word = rd_word;
   assign rsp_payload.word_index  = out_idx_ff;
   assign rsp_payload.last_word   = (out_idx_ff == 3'd7);

   // Sequencer: byte intake, padding, rounds, feed-forward and digest output.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      blk_cnt_in   = blk_cnt_ff;
      round_cnt_in = round_cnt_ff;
      kind_in      = kind_ff;
      eom_pend_in  = eom_pend_ff;
      out_idx_in   = out_idx_ff;

      sched_ctrl           = '0;
      sched_ctrl.pad_mode  = PAD_ONE;
      core_ctrl            = '0;
      core_ctrl.round_idx  = round_cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_payload.has_byte) begin
                  sched_ctrl.byte_we = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     blk_cnt_in   = blk_cnt_ff + 55'd1;
                     core_ctrl.load = 1'b1;
                     round_cnt_in = '0;
                     kind_in      = K_DATA;
                     eom_pend_in  = req_payload.end_of_message;
                     state_in     = S_ROUND;
                  end else if (req_payload.end_of_message) begin
                     state_in = S_PAD;
                  end
               end else if (req_payload.end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            sched_ctrl.pad_en = 1'b1;
            if (fill_ff >= 6'd56) begin
               sched_ctrl.pad_mode = PAD_FIRST;
               kind_in = K_PAD1;
            end else begin
               sched_ctrl.pad_mode = PAD_ONE;
               kind_in = K_LAST;
            end
            core_ctrl.load = 1'b1;
            round_cnt_in   = '0;
            state_in       = S_ROUND;
         end
         S_PAD2: begin
            sched_ctrl.pad_en   = 1'b1;
            sched_ctrl.pad_mode = PAD_SECOND;
            kind_in             = K_LAST;
            core_ctrl.load      = 1'b1;
            round_cnt_in        = '0;
            state_in            = S_ROUND;
         end
         S_ROUND: begin
            core_ctrl.round  = 1'b1;
            sched_ctrl.shift = 1'b1;
            round_cnt_in     = round_cnt_ff + 6'd1;
            if (round_cnt_ff == 6'd63) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            core_ctrl.final_add = 1'b1;
            case (kind_ff)
               K_DATA: begin
                  state_in    = eom_pend_ff ? S_PAD : S_IDLE;
                  eom_pend_in = 1'b0;
               end
               K_PAD1: begin
                  state_in = S_PAD2;
               end
               K_LAST: begin
                  out_idx_in = '0;
                  state_in   = S_OUT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_OUT: begin
            if (rsp_acc) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  core_ctrl.restart = 1'b1;
                  fill_in    = '0;
                  blk_cnt_in = '0;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         blk_cnt_ff   <= '0;
         round_cnt_ff <= '0;
         kind_ff      <= K_DATA;
         eom_pend_ff  <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         blk_cnt_ff   <= blk_cnt_in;
         round_cnt_ff <= round_cnt_in;
         kind_ff      <= kind_in;
         eom_pend_ff  <= eom_pend_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   // Block window and message schedule.
   shs_msg_sched u_sched (
      .clock       (clock),
      .ctrl        (sched_ctrl),
      .fill        (fill_ff),
      .data_byte   (req_payload.data_byte),
      .length_bits (length_bits),
      .w_t         (w_t)
   );

   // Shared round unit and chaining value.
   shs_round_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (core_ctrl),
      .w_t     (w_t),
      .rd_idx  (out_idx_ff),
      .rd_word (rd_word)
   );

   // A byte that completes a block must start the rounds at once.
   a_full_block_compresses: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_payload.has_byte && fill_ff == 6'd63) |=> (state_ff == S_ROUND))
      else $error("full block did not start a compression");

   // The feed-forward add follows exactly the sixty-fourth round.
   a_final_after_round63: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL) |-> ($past(state_ff) == S_ROUND && $past(round_cnt_ff) == 6'd63))
      else $error("feed-forward add not after the last round");

   // After the last digest word the message state is cleared.
   a_restart_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_payload.last_word)
         |=> (state_ff == S_IDLE && fill_ff == 6'd0 && blk_cnt_ff == 55'd0))
      else $error("message state not cleared after digest");

   // Input is never taken while a digest is being delivered.
   a_no_intake_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_acc)
      else $error("input word taken during digest output");

endmodule
